// ----- rtl/lcmo_pkg.sv -----
`timescale 1ns / 1ps

package lcmo_pkg;

    localparam int FB_W     = 8;
    localparam int PERIOD_W = 8;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX = 8'hFF;

    // Verdict of the merge stage for the current matrix power
    typedef struct packed {
        logic done;     // search ends this cycle
        logic found;    // power equals the identity
    } t_verdict;

endpackage

// ----- rtl/lcmo_lane.sv -----
`timescale 1ns / 1ps

// One row of the running matrix power. Multiplying by the companion matrix
// shifts the row up one column and folds the feedback row in when the top
// column was set.
module lcmo_lane #(
    parameter int DEGREE = 8,
    parameter int LANE   = 0
) (
    input  logic              i_clk,
    input  logic              i_load,
    input  logic              i_step,
    input  logic [DEGREE-1:0] i_fb,
    output logic              o_match
);

    localparam logic [DEGREE-1:0] UNIT_ROW = DEGREE'(1) << LANE;

    logic [DEGREE-1:0] r_row;
    logic [DEGREE-1:0] n_row;
    logic [DEGREE-1:0] load_row;

    generate
        if (LANE < DEGREE - 1) begin : g_shift_row
            assign load_row = DEGREE'(1) << (LANE + 1);
        end else begin : g_fb_row
            assign load_row = i_fb;
        end
    endgenerate

    always_comb begin
        n_row = r_row;
        if (i_load) begin
            n_row = load_row;
        end else if (i_step) begin
            n_row = {r_row[DEGREE-2:0], 1'b0} ^ (r_row[DEGREE-1] ? i_fb : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
    end

    assign o_match = (r_row == UNIT_ROW);

endmodule

// ----- rtl/lcmo_merge.sv -----
`timescale 1ns / 1ps

// Combines the per-row matches into the identity test and ends the search
// at the power bound.
module lcmo_merge #(
    parameter int DEGREE = 8
) (
    input  logic [DEGREE-1:0] i_match,
    input  logic [DEGREE:0]   i_count,
    output lcmo_pkg::t_verdict o_verdict
);

    localparam logic [DEGREE:0] LIMIT = (DEGREE+1)'(1) << DEGREE;

    logic identity;

    assign identity        = &i_match;
    assign o_verdict.found = identity;
    assign o_verdict.done  = identity || (i_count == LIMIT);

endmodule

// ----- rtl/lfsr_companion_matrix_order.sv -----
`timescale 1ns / 1ps

// Order of an LFSR companion matrix over GF(2).
// Request channel: drive i_feedback_row and pulse start; the request is
// taken on a rising edge with start high and busy low. Bit j of the row is
// feedback coefficient c_j; bits at or above DEGREE are ignored.
// Result channel: o_valid is high for exactly one cycle with o_period,
// o_singular and o_maximal; the receiver cannot hold it off.
// Timing: a row with c_0 clear (singular) answers in the cycle after the
// request. Otherwise the matrix power advances by one multiply per cycle,
// one lane per row working in parallel, until the power equals the identity
// or the count reaches 2^DEGREE; busy stays high meanwhile. One request is
// worked on at a time: a new one is taken only once the last is answered.
// o_period saturates at 255 for larger orders; o_maximal follows the full
// order. Reset (synchronous, active low) drops busy and any pending strobe.
module lfsr_companion_matrix_order #(
    parameter int DEGREE = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [lcmo_pkg::FB_W-1:0]     i_feedback_row,
    output logic                          o_valid,
    output logic [lcmo_pkg::PERIOD_W-1:0] o_period,
    output logic                          o_singular,
    output logic                          o_maximal
);

    localparam int CNT_W = DEGREE + 1;
    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(1) << DEGREE;
    localparam logic [CNT_W-1:0] FULL  = LIMIT - CNT_W'(1);

    logic [DEGREE-1:0] fb_in;
    logic [DEGREE-1:0] r_fb;
    logic [DEGREE-1:0] match;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_run;
    logic              n_run;
    logic              r_valid;
    logic              n_valid;
    logic [lcmo_pkg::PERIOD_W-1:0] r_period;
    logic [lcmo_pkg::PERIOD_W-1:0] n_period;
    logic              r_singular;
    logic              n_singular;
    logic              r_maximal;
    logic              n_maximal;
    logic              accept;
    logic              load;
    logic              step;
    logic [31:0]       count_ext;
    lcmo_pkg::t_verdict verdict;

    genvar j;
    generate
        for (j = 0; j < DEGREE; j++) begin : g_fb
            if (j < lcmo_pkg::FB_W) begin : g_used
                assign fb_in[j] = i_feedback_row[j];
            end else begin : g_zero
                assign fb_in[j] = 1'b0;
            end
        end
    endgenerate

    assign accept = start && !r_run;
    assign load   = accept && fb_in[0];
    assign step   = r_run && !verdict.done;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_fb <= fb_in;
        end
    end

    generate
        for (j = 0; j < DEGREE; j++) begin : g_lane
            lcmo_lane #(
                .DEGREE (DEGREE),
                .LANE   (j)
            ) u_lane (
                .i_clk   (i_clk),
                .i_load  (load),
                .i_step  (step),
                .i_fb    ((j == DEGREE - 1) && load ? fb_in : r_fb),
                .o_match (match[j])
            );
        end
    endgenerate

    lcmo_merge #(
        .DEGREE (DEGREE)
    ) u_merge (
        .i_match   (match),
        .i_count   (r_count),
        .o_verdict (verdict)
    );

    assign count_ext = 32'(r_count);

    always_comb begin
        n_run      = r_run;
        n_count    = r_count;
        n_valid    = 1'b0;
        n_period   = r_period;
        n_singular = r_singular;
        n_maximal  = r_maximal;
        if (r_run) begin
            if (verdict.done) begin
                n_run      = 1'b0;
                n_valid    = 1'b1;
                n_singular = 1'b0;
                if (verdict.found) begin
                    n_period  = (count_ext > 32'(lcmo_pkg::PERIOD_MAX)) ?
                                lcmo_pkg::PERIOD_MAX :
                                count_ext[lcmo_pkg::PERIOD_W-1:0];
                    n_maximal = (r_count == FULL);
                end else begin
                    n_period  = '0;
                    n_maximal = 1'b0;
                end
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else if (accept) begin
            if (fb_in[0]) begin
                n_run   = 1'b1;
                n_count = CNT_W'(1);
            end else begin
                // no constant term: singular, answer at once
                n_valid    = 1'b1;
                n_period   = '0;
                n_singular = 1'b1;
                n_maximal  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_run   <= n_run;
            r_valid <= n_valid;
        end
        r_count    <= n_count;
        r_period   <= n_period;
        r_singular <= n_singular;
        r_maximal  <= n_maximal;
    end

    assign busy       = r_run;
    assign o_valid    = r_valid;
    assign o_period   = r_period;
    assign o_singular = r_singular;
    assign o_maximal  = r_maximal;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> (r_count != '0) && (r_count <= LIMIT))
        else $error("power count out of range");

    a_singular_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !fb_in[0]) |=> (o_valid && o_singular && !busy))
        else $error("singular request not answered next cycle");

    a_singular_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_singular) |-> (o_period == '0) && !o_maximal)
        else $error("singular result carries order");

    a_result_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_singular) |-> $past(r_run) && !r_run)
        else $error("result without finished search");

    a_maximal_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_maximal) |-> (o_period != '0))
        else $error("maximal flag with zero period");

endmodule

// ----- test/tb_lfsr_companion_matrix_order.sv -----
`timescale 1ns / 1ps

module tb_lfsr_companion_matrix_order;

    localparam int DEGREE      = 8;
    localparam int NUM_RANDOM  = 650;
    localparam int DRAIN_WAIT  = (1 << DEGREE) + 8;

    typedef logic [DEGREE-1:0] t_row;

    typedef struct {
        logic [lcmo_pkg::FB_W-1:0]     feedback;
        logic [lcmo_pkg::PERIOD_W-1:0] period;
        logic                          singular;
        logic                          maximal;
    } t_order_result;

    // Works out the matrix order for each accepted request and keeps the
    // results still owed by the block, oldest first.
    class order_scoreboard;
        t_order_result owed[$];
        int            errors    = 0;
        int            requests  = 0;
        int            results   = 0;
        int            singulars = 0;
        int            maximals  = 0;

        function t_order_result order_of_row(logic [lcmo_pkg::FB_W-1:0] feedback);
            t_order_result res;
            t_row          comp  [DEGREE];
            t_row          power [DEGREE];
            t_row          prod  [DEGREE];
            t_row          fb;
            int            order;
            bit            ident;
            fb           = t_row'(feedback);
            res.feedback = feedback;
            res.period   = '0;
            res.singular = 1'b0;
            res.maximal  = 1'b0;
            if (!fb[0]) begin
                res.singular = 1'b1;
                return res;
            end
            for (int i = 0; i < DEGREE - 1; i++) comp[i] = t_row'(1) << (i + 1);
            comp[DEGREE-1] = fb;
            power = comp;
            order = 0;
            for (int n = 1; n <= (1 << DEGREE); n++) begin
                ident = 1'b1;
                for (int i = 0; i < DEGREE; i++)
                    if (power[i] != (t_row'(1) << i)) ident = 1'b0;
                if (ident) begin
                    order = n;
                    break;
                end
                // next power: row i of power selects rows of comp to XOR
                for (int i = 0; i < DEGREE; i++) begin
                    prod[i] = '0;
                    for (int k = 0; k < DEGREE; k++)
                        if (power[i][k]) prod[i] ^= comp[k];
                end
                power = prod;
            end
            res.period  = (order > 255) ? lcmo_pkg::PERIOD_MAX :
                          lcmo_pkg::PERIOD_W'(order);
            res.maximal = (order != 0) && (order == (1 << DEGREE) - 1);
            return res;
        endfunction

        function void note_row(logic [lcmo_pkg::FB_W-1:0] feedback);
            owed.push_back(order_of_row(feedback));
            requests++;
        endfunction

        function void check_result(logic [lcmo_pkg::PERIOD_W-1:0] period, logic singular,
                                   logic maximal);
            t_order_result exp_res;
            results++;
            if (owed.size() == 0) begin
                $display("%0t: result with no request outstanding (period %0d)",
                         $time, period);
                errors++;
                return;
            end
            exp_res = owed.pop_front();
            if (singular) singulars++;
            if (maximal) maximals++;
            if (period !== exp_res.period) begin
                $display("%0t: row %02h period expected %0d actual %0d",
                         $time, exp_res.feedback, exp_res.period, period);
                errors++;
            end
            if (singular !== exp_res.singular) begin
                $display("%0t: row %02h singular expected %0b actual %0b",
                         $time, exp_res.feedback, exp_res.singular, singular);
                errors++;
            end
            if (maximal !== exp_res.maximal) begin
                $display("%0t: row %02h maximal expected %0b actual %0b",
                         $time, exp_res.feedback, exp_res.maximal, maximal);
                errors++;
            end
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic [lcmo_pkg::FB_W-1:0]     i_feedback_row;
    logic                          o_valid;
    logic [lcmo_pkg::PERIOD_W-1:0] o_period;
    logic                          o_singular;
    logic                          o_maximal;

    order_scoreboard sb;

    lfsr_companion_matrix_order #(
        .DEGREE (DEGREE)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_feedback_row (i_feedback_row),
        .o_valid        (o_valid),
        .o_period       (o_period),
        .o_singular     (o_singular),
        .o_maximal      (o_maximal)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_period, o_singular, o_maximal);
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    // With no gap, start simply stays high for the next request.
    task automatic send_row(input logic [lcmo_pkg::FB_W-1:0] row, input int gap);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) begin
                i_feedback_row = lcmo_pkg::FB_W'($urandom);
                @(negedge i_clk);
            end
        end
        start          = 1'b1;
        i_feedback_row = row;
        do @(posedge i_clk); while (busy);
        sb.note_row(row);
        @(negedge i_clk);
    endtask

    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        logic [lcmo_pkg::FB_W-1:0] directed[$];
        bit                        no_idle;
        sb = new();
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_feedback_row = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // extremes, singular rows, plain shift, known primitive and
        // non-primitive rows
        directed = {8'h00, 8'hFF, 8'h01, 8'hFE, 8'h80, 8'h81, 8'h7F, 8'h02,
                    8'h1D, 8'h2B, 8'h03, 8'h55, 8'hAA, 8'h11, 8'h8F, 8'hC3,
                    8'h71, 8'h0F, 8'hF1, 8'h3F};
        foreach (directed[i]) send_row(directed[i], $urandom_range(0, 4));

        no_idle = 1'b0;
        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i % 50 == 0) no_idle = ($urandom_range(0, 2) == 0);
            send_row(lcmo_pkg::FB_W'($urandom_range(0, 255)),
                     no_idle ? 0 : $urandom_range(0, 4));
        end
        start = 1'b0;

        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Checked %0d requests against %0d results", sb.requests, sb.results);
        $display("Singular rows: %0d, maximal-period rows: %0d", sb.singulars,
                 sb.maximals);
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/lcmo_pkg.sv
rtl/lcmo_lane.sv
rtl/lcmo_merge.sv
rtl/lfsr_companion_matrix_order.sv
test/tb_lfsr_companion_matrix_order.sv
